// ===== design/grp_pkg.sv =====
// ----------------------------------------------------------------------------
// grp_pkg: grid route planner constants
// Road map tables, node coordinates and turn codes for the 3x3 grid.
// ----------------------------------------------------------------------------
package grp_pkg;

  localparam int NUM_NODES = 9;
  localparam int NUM_EDGES = 12;
  localparam logic [16:0] BLOCKED_COST = 17'd10000;

  localparam logic [2:0] TURN_NONE    = 3'd0;
  localparam logic [2:0] TURN_FORWARD = 3'd1;
  localparam logic [2:0] TURN_BACK    = 3'd2;
  localparam logic [2:0] TURN_LEFT    = 3'd3;
  localparam logic [2:0] TURN_RIGHT   = 3'd4;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_PLAN  = 1'b1;

  localparam logic [3:0] ROAD_A [NUM_EDGES] = '{
    4'd0, 4'd0, 4'd6, 4'd7, 4'd4, 4'd3, 4'd4, 4'd7, 4'd0, 4'd2, 4'd1, 4'd2};
  localparam logic [3:0] ROAD_B [NUM_EDGES] = '{
    4'd1, 4'd6, 4'd7, 4'd8, 4'd8, 4'd4, 4'd5, 4'd5, 4'd5, 4'd5, 4'd2, 4'd3};
  localparam logic [2:0] ADJ_COUNT [NUM_NODES] = '{
    3'd3, 3'd2, 3'd3, 3'd2, 3'd3, 3'd4, 3'd2, 3'd3, 3'd2};
  localparam logic [3:0] ADJ_LIST [NUM_NODES][4] = '{
    '{4'd0, 4'd1, 4'd8, 4'd0}, '{4'd0, 4'd10, 4'd0, 4'd0},
    '{4'd10, 4'd9, 4'd11, 4'd0}, '{4'd11, 4'd5, 4'd0, 4'd0},
    '{4'd6, 4'd4, 4'd5, 4'd0}, '{4'd6, 4'd9, 4'd8, 4'd7},
    '{4'd2, 4'd1, 4'd0, 4'd0}, '{4'd2, 4'd3, 4'd7, 4'd0},
    '{4'd3, 4'd4, 4'd0, 4'd0}};
  localparam logic signed [2:0] NODE_X [NUM_NODES] = '{
    3'sd0, -3'sd1, -3'sd1, -3'sd1, 3'sd0, 3'sd0, 3'sd1, 3'sd1, 3'sd1};
  localparam logic signed [2:0] NODE_Y [NUM_NODES] = '{
    3'sd1, 3'sd1, 3'sd0, -3'sd1, -3'sd1, 3'sd0, 3'sd1, 3'sd0, -3'sd1};

  function automatic logic [3:0] far_end(input logic [3:0] e, input logic [3:0] n);
    far_end = (ROAD_A[e] == n) ? ROAD_B[e] : ROAD_A[e];
  endfunction

endpackage

// ===== design/grid_route_planner_with_turns.sv =====
// ----------------------------------------------------------------------------
// grid_route_planner_with_turns
// Cheapest simple route on a 3x3 road grid, delivered as a list of turns.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low.
// command_i = write: the road cost at edge_index_i is replaced (indexes above
//   11 are ignored); done in the accepting cycle, no result, busy_o stays low.
// command_i = plan: a depth-first search over simple paths from start_node_i
//   to end_node_i runs on a stack of node/edge-cursor/cost registers, with road
//   costs in a 12-entry synchronous memory. Each tried edge takes a cursor
//   step plus a memory read; each skipped edge takes only the cursor step,
//   and each backtrack only the stack pop.
// Results then follow one per cycle on valid_o, one per route step (or a
//   single result with no turn when start equals goal or no route exists),
//   last_o on the final one. The receiver cannot stall; results are never held.
// Reset clears all road costs to zero and returns the block to idle.
// ----------------------------------------------------------------------------
module grid_route_planner_with_turns #(
  parameter int MAX_ROUTE_NODES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        command_i,
  input  logic [3:0]  edge_index_i,
  input  logic [13:0] edge_weight_i,
  input  logic [3:0]  start_node_i,
  input  logic [3:0]  end_node_i,
  input  logic signed [1:0] heading_x_i,
  input  logic signed [1:0] heading_y_i,
  output logic        valid_o,
  output logic [2:0]  turn_code_o,
  output logic [2:0]  step_index_o,
  output logic [3:0]  route_node_o,
  output logic [16:0] total_cost_o,
  output logic        last_o
);
  import grp_pkg::*;

  localparam int DW = $clog2(MAX_ROUTE_NODES);
  localparam int LW = $clog2(MAX_ROUTE_NODES + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXPAND = 2'd1;
  localparam logic [1:0] S_LOAD   = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0]  state_q;
  logic [DW-1:0] depth_q, oidx_q;
  logic [3:0]  node_s_q [MAX_ROUTE_NODES];
  logic [2:0]  kidx_q [MAX_ROUTE_NODES];
  logic [16:0] cost_s_q [MAX_ROUTE_NODES];
  logic [3:0]  best_route_q [MAX_ROUTE_NODES];
  logic [NUM_NODES-1:0] visited_q;
  logic [3:0]  nb_q, goal_q, start_q, prev_q;
  logic [16:0] best_cost_q;
  logic [LW-1:0] best_len_q;
  logic signed [2:0] hx_q, hy_q;

  logic [13:0] wmem_q [NUM_EDGES];
  logic [NUM_EDGES-1:0] wvalid_q;
  logic [13:0] rdata_q;
  logic        rvalid_q;

  logic        accept, we, rd_en;
  logic [3:0]  cur_n, cur_e, cur_nb;
  logic [2:0]  cur_k;
  logic        exhausted, room;
  logic [16:0] new_cost;
  logic [DW-1:0] dp1, op1;
  logic [LW-1:0] steps;
  logic [3:0]  nxt_b;
  logic signed [2:0] dx, dy, nhx_d, nhy_d;
  logic [2:0]  turn_d;

  assign accept = start_i && (state_q == S_IDLE);
  assign we = accept && (command_i == CMD_WRITE) && (edge_index_i < 4'(NUM_EDGES));
  assign busy_o = (state_q != S_IDLE);

  assign cur_n = node_s_q[depth_q];
  assign cur_k = kidx_q[depth_q];
  assign exhausted = (cur_k >= ADJ_COUNT[cur_n]);
  assign cur_e = ADJ_LIST[cur_n][cur_k[1:0]];
  assign cur_nb = far_end(cur_e, cur_n);
  assign room = ((LW)'(depth_q) + 1'b1) < (LW)'(MAX_ROUTE_NODES);
  assign rd_en = (state_q == S_EXPAND) && !exhausted && !visited_q[cur_nb] && room;
  assign new_cost = cost_s_q[depth_q] + {3'b000, (rvalid_q ? rdata_q : 14'd0)};
  assign dp1 = depth_q + 1'b1;
  assign op1 = oidx_q + 1'b1;
  assign steps = (best_len_q > 1) ? best_len_q - 1'b1 : '0;
  assign nxt_b = best_route_q[op1];

  always_comb begin
    dx = NODE_X[nxt_b] - NODE_X[prev_q];
    dy = NODE_Y[nxt_b] - NODE_Y[prev_q];
    if (dx == hx_q && dy == hy_q) begin
      turn_d = TURN_FORWARD; nhx_d = hx_q; nhy_d = hy_q;
    end else if (dx == -hx_q && dy == -hy_q) begin
      turn_d = TURN_BACK; nhx_d = -hx_q; nhy_d = -hy_q;
    end else if (hx_q != 0) begin
      if (dx == hy_q && dy == hx_q) begin
        turn_d = TURN_LEFT; nhx_d = hy_q; nhy_d = hx_q;
      end else begin
        turn_d = TURN_RIGHT; nhx_d = hy_q; nhy_d = -hx_q;
      end
    end else begin
      if (dx == -hy_q && dy == -hx_q) begin
        turn_d = TURN_LEFT; nhx_d = -hy_q; nhy_d = hx_q;
      end else begin
        turn_d = TURN_RIGHT; nhx_d = hy_q; nhy_d = hx_q;
      end
    end
  end

  // road cost memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      wmem_q[edge_index_i] <= edge_weight_i;
    end
    if (rd_en) begin
      rdata_q <= wmem_q[cur_e];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wvalid_q <= '0;
      rvalid_q <= 1'b0;
      visited_q <= '0;
      best_cost_q <= '0;
      best_len_q <= '0;
      depth_q <= '0;
      oidx_q <= '0;
      valid_o <= 1'b0;
      last_o <= 1'b0;
      turn_code_o <= TURN_NONE;
      step_index_o <= '0;
      route_node_o <= '0;
      total_cost_o <= '0;
    end else begin
      valid_o <= 1'b0;
      last_o <= 1'b0;
      if (we) begin
        wvalid_q[edge_index_i] <= 1'b1;
      end
      if (rd_en) begin
        rvalid_q <= wvalid_q[cur_e];
      end
      case (state_q)
        S_IDLE: begin
          if (accept && command_i == CMD_PLAN) begin
            start_q <= start_node_i;
            goal_q <= end_node_i;
            prev_q <= start_node_i;
            hx_q <= 3'(heading_x_i);
            hy_q <= 3'(heading_y_i);
            oidx_q <= '0;
            depth_q <= '0;
            node_s_q[0] <= start_node_i;
            kidx_q[0] <= '0;
            cost_s_q[0] <= '0;
            best_len_q <= '0;
            best_cost_q <= BLOCKED_COST;
            if (start_node_i >= 4'(NUM_NODES) || end_node_i >= 4'(NUM_NODES)) begin
              state_q <= S_EMIT;
            end else if (start_node_i == end_node_i) begin
              best_cost_q <= '0;
              best_len_q <= LW'(1);
              state_q <= S_EMIT;
            end else begin
              visited_q <= NUM_NODES'(1) << start_node_i;
              state_q <= S_EXPAND;
            end
          end
        end
        S_EXPAND: begin
          if (exhausted) begin
            visited_q[cur_n] <= 1'b0;
            if (depth_q == '0) begin
              state_q <= S_EMIT;
            end else begin
              depth_q <= depth_q - 1'b1;
            end
          end else begin
            kidx_q[depth_q] <= cur_k + 1'b1;
            nb_q <= cur_nb;
            if (rd_en) begin
              state_q <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          state_q <= S_EXPAND;
          if (nb_q == goal_q) begin
            if (new_cost < best_cost_q) begin
              best_cost_q <= new_cost;
              best_len_q <= LW'(depth_q) + LW'(2);
              for (int j = 0; j < MAX_ROUTE_NODES; j++) begin
                if (DW'(j) == dp1) begin
                  best_route_q[j] <= nb_q;
                end else if (DW'(j) <= depth_q) begin
                  best_route_q[j] <= node_s_q[j];
                end
              end
            end
          end else begin
            depth_q <= dp1;
            node_s_q[dp1] <= nb_q;
            kidx_q[dp1] <= '0;
            cost_s_q[dp1] <= new_cost;
            visited_q[nb_q] <= 1'b1;
          end
        end
        S_EMIT: begin
          valid_o <= 1'b1;
          total_cost_o <= best_cost_q;
          step_index_o <= 3'(oidx_q);
          if (steps == '0) begin
            turn_code_o <= TURN_NONE;
            route_node_o <= start_q;
            last_o <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            turn_code_o <= turn_d;
            route_node_o <= nxt_b;
            hx_q <= nhx_d;
            hy_q <= nhy_d;
            prev_q <= nxt_b;
            oidx_q <= op1;
            if (LW'(op1) == steps) begin
              last_o <= 1'b1;
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> valid_o) else $error("last without result");
  a_steps_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |=> valid_o && step_index_o == $past(step_index_o) + 3'd1)
    else $error("result run broken");
  a_busy_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |-> busy_o) else $error("idle during result run");

endmodule

// ===== test/tb_grid_route_planner_with_turns.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_route_planner_with_turns: route planner self-checking bench
// Directed table of road writes and plans, then random traffic, with every
// turn result compared against a behavioural search model held in the bench.
// ----------------------------------------------------------------------------
module tb_grid_route_planner_with_turns;
  import grp_pkg::*;

  typedef struct packed {
    logic [2:0]  turn;
    logic [2:0]  step;
    logic [3:0]  node;
    logic [16:0] cost;
    logic        last;
  } turn_t;

  typedef struct {
    logic        cmd;
    logic [3:0]  edge_idx;
    logic [13:0] weight;
    logic [3:0]  src;
    logic [3:0]  dst;
    logic [1:0]  hx;
    logic [1:0]  hy;
    logic        chk;
    turn_t       exp_first;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        command_i = 1'b0;
  logic [3:0]  edge_index_i = '0;
  logic [13:0] edge_weight_i = '0;
  logic [3:0]  start_node_i = '0;
  logic [3:0]  end_node_i = '0;
  logic signed [1:0] heading_x_i = '0;
  logic signed [1:0] heading_y_i = '0;
  logic        busy_o, valid_o, last_o;
  logic [2:0]  turn_code_o, step_index_o;
  logic [3:0]  route_node_o;
  logic [16:0] total_cost_o;

  grid_route_planner_with_turns u_dut (.*);

  always #1 clk_i = ~clk_i;

  logic [13:0] road_cost [NUM_EDGES];
  logic [3:0]  path [8];
  logic [3:0]  best_path [8];
  int          best_n;
  int          best_sum;
  int          goal;
  logic [8:0]  seen;
  turn_t       expected_turns [$];
  int          errors = 0;
  int          plans = 0, writes = 0, turns_seen = 0;

  function automatic int other_end(int e, int n);
    return (ROAD_A[e] == n) ? int'(ROAD_B[e]) : int'(ROAD_A[e]);
  endfunction

  task automatic search(int n, int depth, int sum);
    int e, nb;
    path[depth] = 4'(n);
    if (n == goal) begin
      if (sum < best_sum) begin
        best_sum = sum;
        for (int i = 0; i <= depth; i++) best_path[i] = path[i];
        best_n = depth + 1;
      end
      return;
    end
    seen[n] = 1'b1;
    for (int k = 0; k < ADJ_COUNT[n]; k++) begin
      e = ADJ_LIST[n][k];
      nb = other_end(e, n);
      if (!seen[nb] && depth + 1 < 8) search(nb, depth + 1, sum + road_cost[e]);
    end
    seen[n] = 1'b0;
  endtask

  task automatic predict_plan(logic [3:0] s, logic [3:0] g, logic [1:0] hxi, logic [1:0] hyi);
    int hx, hy, dx, dy, t, steps;
    turn_t r;
    hx = $signed(hxi);
    hy = $signed(hyi);
    best_n = 0;
    seen = '0;
    if (s < NUM_NODES && g < NUM_NODES) begin
      if (s == g) begin
        best_sum = 0;
        best_path[0] = s;
        best_n = 1;
      end else begin
        best_sum = BLOCKED_COST;
        goal = g;
        search(s, 0, 0);
      end
    end else best_sum = BLOCKED_COST;
    if (best_sum > 17'h1FFFF) best_sum = 17'h1FFFF;
    steps = (best_n > 1) ? best_n - 1 : 0;
    if (steps == 0) begin
      r = '{TURN_NONE, 3'd0, s, best_sum[16:0], 1'b1};
      expected_turns.push_back(r);
      return;
    end
    for (int i = 0; i < steps; i++) begin
      dx = NODE_X[best_path[i+1]] - NODE_X[best_path[i]];
      dy = NODE_Y[best_path[i+1]] - NODE_Y[best_path[i]];
      if (dx == hx && dy == hy) r.turn = TURN_FORWARD;
      else if (dx == -hx && dy == -hy) begin
        r.turn = TURN_BACK; hx = -hx; hy = -hy;
      end else if (hx != 0) begin
        if (dx == hy && dy == hx) begin
          r.turn = TURN_LEFT; t = hy; hy = hx; hx = t;
        end else begin
          r.turn = TURN_RIGHT; t = hy; hy = -hx; hx = t;
        end
      end else begin
        if (dx == -hy && dy == -hx) begin
          r.turn = TURN_LEFT; t = hy; hy = hx; hx = -t;
        end else begin
          r.turn = TURN_RIGHT; t = hy; hy = hx; hx = t;
        end
      end
      r.step = 3'(i);
      r.node = best_path[i+1];
      r.cost = best_sum[16:0];
      r.last = (i + 1 == steps);
      expected_turns.push_back(r);
    end
  endtask

  task automatic report(string what, turn_t e, turn_t a);
    errors++;
    if (errors <= 10)
      $display("MISMATCH %s: exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
               what, e.turn, e.step, e.node, e.cost, e.last, a.turn, a.step, a.node, a.cost,
               a.last);
  endtask

  always @(posedge clk_i) begin
    turn_t a, e;
    if (valid_o) begin
      a = '{turn_code_o, step_index_o, route_node_o, total_cost_o, last_o};
      turns_seen++;
      if (expected_turns.size() == 0) report("unexpected", '0, a);
      else begin
        e = expected_turns.pop_front();
        if (a !== e) report("field", e, a);
      end
    end
  end

  // start_i stays high into the next request when no idle cycles are drawn
  task automatic issue(row_t r);
    int gap;
    gap = $urandom_range(0, 7);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    command_i <= r.cmd;
    edge_index_i <= r.edge_idx;
    edge_weight_i <= r.weight;
    start_node_i <= r.src;
    end_node_i <= r.dst;
    heading_x_i <= r.hx;
    heading_y_i <= r.hy;
    do @(posedge clk_i); while (busy_o);
    if (r.cmd == CMD_WRITE) begin
      writes++;
      if (r.edge_idx < NUM_EDGES) road_cost[r.edge_idx] = r.weight;
    end else begin
      plans++;
      predict_plan(r.src, r.dst, r.hx, r.hy);
      if (r.chk && expected_turns[$] !== r.exp_first)
        report("table", r.exp_first, expected_turns[$]);
    end
  endtask

  function automatic row_t wr(int e, int w);
    row_t r;
    r = '{CMD_WRITE, e[3:0], w[13:0], 4'd0, 4'd0, 2'b00, 2'b00, 1'b0, '0};
    return r;
  endfunction

  function automatic row_t pl(int s, int g, int hx, int hy, bit chk = 0, int cost = 0);
    row_t r;
    r = '{CMD_PLAN, 4'd0, 14'd0, s[3:0], g[3:0], hx[1:0], hy[1:0], chk,
          '{TURN_NONE, 3'd0, s[3:0], cost[16:0], 1'b1}};
    return r;
  endfunction

  row_t directed [$];

  initial begin
    row_t r;
    int   k;
    for (int i = 0; i < NUM_EDGES; i++) road_cost[i] = '0;
    directed = '{
      pl(4, 4, 0, 1, 1, 0), pl(0, 8, 0, 1), pl(3, 6, -1, 0), pl(9, 2, 1, 0, 1, 10000),
      pl(2, 15, 0, -1, 1, 10000), wr(0, 16383), wr(1, 10000), wr(8, 10000),
      pl(0, 5, 1, 0, 1, 10000), wr(15, 5), wr(12, 7), wr(0, 1), wr(1, 9999),
      wr(8, 3), pl(0, 8, 0, 1), pl(8, 0, -1, -2), pl(1, 7, 1, 1), wr(5, 16383),
      wr(11, 16383), pl(3, 6, 0, 0), pl(6, 3, 1, 0)};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) issue(directed[i]);
    for (int n = 0; n < 140; n++) begin
      k = $urandom_range(0, 9);
      if (k < 3) begin
        r = wr($urandom_range(0, 15), 0);
        r.weight = (k == 0) ? 14'($urandom_range(0, 16383)) :
                   (k == 1) ? 14'($urandom_range(0, 40)) : 14'(BLOCKED_COST);
      end else begin
        r = pl($urandom_range(0, 8), $urandom_range(0, 8), $urandom_range(0, 3),
               $urandom_range(0, 3));
        if (k == 9) begin
          r.src = 4'($urandom_range(0, 15));
          r.dst = 4'($urandom_range(0, 15));
        end
      end
      issue(r);
    end
    start_i <= 1'b0;
    while (expected_turns.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Covered %0d plans and %0d road writes, %0d turn results checked.",
             plans, writes, turns_seen);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #4000000;
    $display("Timeout waiting for results");
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/grp_pkg.sv
design/grid_route_planner_with_turns.sv
test/tb_grid_route_planner_with_turns.sv
